// ===== rtl/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Table partition fingerprint package
// Shared types and constants for the fingerprint core and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tpf_pkg;

    localparam int MAX_SLOTS = 2048;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int          FNV_PRIME_SH = 40;
    localparam logic [63:0] HASH_RESET   = 64'h077934407C79A117;
    localparam int          COMMON_SH    = 3;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_IMAGE_BASE    = 1'b0;
    localparam cfg_idx_t CFG_EXPECTED_HASH = 1'b1;

    typedef struct packed {
        logic [63:0] entry_value;
        logic        last_entry;
    } req_t;

    typedef struct packed {
        logic [10:0] first_slot;
        logic        done_res;
        logic [63:0] partition_hash;
        logic        hash_matches;
        logic [11:0] distinct_count;
        logic        common_found;
        logic [31:0] common_offset;
        logic [11:0] common_count;
    } res_t;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SRD  = 9'b000000010,
        ST_SCMP = 9'b000000100,
        ST_INS  = 9'b000001000,
        ST_HASH = 9'b000010000,
        ST_CRD  = 9'b000100000,
        ST_CCMP = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/tpf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tpf_fnv_step.sv =====
// ----------------------------------------------------------------------------
// FNV-1a step
// Folds one byte into a 64-bit FNV-1a hash: xor, then multiply by the prime.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_fnv_step (
    input  wire logic [63:0] hash,
    input  wire logic [7:0]  data,
    output logic      [63:0] result
);

    logic [63:0] mixed;

    // prime = 2^40 + 0x1B3
    always_comb
    begin
        mixed  = hash ^ {56'd0, data};
        result = (mixed << tpf_pkg::FNV_PRIME_SH)
               + (mixed * {55'd0, tpf_pkg::FNV_PRIME_LO});
    end

endmodule

`default_nettype wire

// ===== rtl/table_partition_fingerprint_core.sv =====
// ----------------------------------------------------------------------------
// Table partition fingerprint core
// Maps each table entry to its first slot, hashes those slots, and reports
// a summary with the commonest nonzero value on the last entry.
// ----------------------------------------------------------------------------
// One request at a time. While slots remain, a sequencer reads the value map
// (one RAM read port) one stored value at a time, in a read state and then a
// compare state, until it hits or reaches the end and inserts the entry, then
// runs four FNV byte steps through one shared multiply unit. The last entry
// also scans the map the same way for the commonest value. The map is emptied
// by resetting its fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module table_partition_fingerprint_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire tpf_pkg::req_t         req_data,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output tpf_pkg::res_t              res_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire tpf_pkg::cfg_idx_t     cfg_index,
    input  wire logic [63:0]           cfg_data
);

    localparam int SW = tpf_pkg::SLOT_W;
    localparam int CW = tpf_pkg::CNT_W;

    tpf_pkg::state_t state_reg, state_next;
    logic [63:0]   base_reg, base_next;
    logic [63:0]   exp_reg, exp_next;
    logic [63:0]   val_reg, val_next;
    logic          last_reg, last_next;
    logic [SW-1:0] first_reg, first_next;
    logic [SW-1:0] k_reg, k_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [CW-1:0] dist_reg, dist_next;
    logic [63:0]   hash_reg, hash_next;
    logic [1:0]    step_reg, step_next;
    logic          any_reg, any_next;
    logic [63:0]   bval_reg, bval_next;
    logic [CW-1:0] bcnt_reg, bcnt_next;
    tpf_pkg::res_t res_reg, res_next;

    logic          map_we;
    logic          cnt_we;
    logic [SW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic [63:0]   val_q;
    logic [SW-1:0] first_q;
    logic [CW-1:0] cnt_q;
    logic [7:0]    hash_byte;
    logic [63:0]   hash_step;
    logic          k_end;
    logic [63:0]   diff;

    tpf_ram #(.WIDTH(64), .DEPTH(tpf_pkg::MAX_SLOTS)) u_val_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (fill_reg[SW-1:0]),
        .wdata (val_reg),
        .raddr (k_reg),
        .rdata (val_q)
    );

    tpf_ram #(.WIDTH(SW), .DEPTH(tpf_pkg::MAX_SLOTS)) u_first_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (fill_reg[SW-1:0]),
        .wdata (slot_reg[SW-1:0]),
        .raddr (k_reg),
        .rdata (first_q)
    );

    tpf_ram #(.WIDTH(CW), .DEPTH(tpf_pkg::MAX_SLOTS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (k_reg),
        .rdata (cnt_q)
    );

    tpf_fnv_step u_fnv (
        .hash   (hash_reg),
        .data   (hash_byte),
        .result (hash_step)
    );

    assign req_stall = (state_reg != tpf_pkg::ST_IDLE);
    assign res_valid = (state_reg == tpf_pkg::ST_OUT);
    assign res_data  = res_reg;
    assign cfg_ready = 1'b1;

    assign k_end = (({1'b0, k_reg} + {{(CW-1){1'b0}}, 1'b1}) == fill_reg);
    assign diff  = bval_reg - base_reg;

    always_comb
    begin
        unique case (step_reg)
            2'd0: hash_byte = first_reg[7:0];
            2'd1: hash_byte = {{(16-SW){1'b0}}, first_reg[SW-1:8]};
            2'd2: hash_byte = 8'd0;
            2'd3: hash_byte = 8'd0;
            default: hash_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        first_next = first_reg;
        k_next     = k_reg;
        fill_next  = fill_reg;
        slot_next  = slot_reg;
        dist_next  = dist_reg;
        hash_next  = hash_reg;
        step_next  = step_reg;
        any_next   = any_reg;
        bval_next  = bval_reg;
        bcnt_next  = bcnt_reg;
        res_next   = res_reg;
        map_we     = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = fill_reg[SW-1:0];
        cnt_wdata  = {{(CW-1){1'b0}}, 1'b1};

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpf_pkg::CFG_IMAGE_BASE:    base_next = cfg_data;
                tpf_pkg::CFG_EXPECTED_HASH: exp_next  = cfg_data;
                default:                    base_next = base_reg;
            endcase
        end

        unique case (state_reg)
            tpf_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    val_next  = req_data.entry_value;
                    last_next = req_data.last_entry;
                    k_next    = '0;
                    any_next  = 1'b0;
                    bval_next = '0;
                    bcnt_next = '0;
                    res_next  = '0;
                    if (slot_reg < CW'(tpf_pkg::MAX_SLOTS))
                    begin
                        state_next = (fill_reg == '0) ? tpf_pkg::ST_INS : tpf_pkg::ST_SRD;
                    end
                    else if (req_data.last_entry)
                    begin
                        state_next = (fill_reg == '0) ? tpf_pkg::ST_FIN : tpf_pkg::ST_CRD;
                    end
                    else
                    begin
                        state_next = tpf_pkg::ST_OUT;
                    end
                end
            end
            tpf_pkg::ST_SRD:
            begin
                state_next = tpf_pkg::ST_SCMP;
            end
            tpf_pkg::ST_SCMP:
            begin
                if (val_q == val_reg)
                begin
                    first_next = first_q;
                    cnt_we     = 1'b1;
                    cnt_waddr  = k_reg;
                    cnt_wdata  = cnt_q + {{(CW-1){1'b0}}, 1'b1};
                    step_next  = '0;
                    state_next = tpf_pkg::ST_HASH;
                end
                else if (k_end)
                begin
                    state_next = tpf_pkg::ST_INS;
                end
                else
                begin
                    k_next     = k_reg + {{(SW-1){1'b0}}, 1'b1};
                    state_next = tpf_pkg::ST_SRD;
                end
            end
            tpf_pkg::ST_INS:
            begin
                map_we     = 1'b1;
                cnt_we     = 1'b1;
                first_next = slot_reg[SW-1:0];
                fill_next  = fill_reg + {{(CW-1){1'b0}}, 1'b1};
                if (val_reg != '0)
                begin
                    dist_next = dist_reg + {{(CW-1){1'b0}}, 1'b1};
                end
                step_next  = '0;
                state_next = tpf_pkg::ST_HASH;
            end
            tpf_pkg::ST_HASH:
            begin
                hash_next = hash_step;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    slot_next = slot_reg + {{(CW-1){1'b0}}, 1'b1};
                    res_next.first_slot = first_reg;
                    k_next = '0;
                    if (!last_reg)
                    begin
                        state_next = tpf_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = tpf_pkg::ST_CRD;
                    end
                end
            end
            tpf_pkg::ST_CRD:
            begin
                state_next = tpf_pkg::ST_CCMP;
            end
            tpf_pkg::ST_CCMP:
            begin
                if ((val_q != '0) && (!any_reg || (cnt_q > bcnt_reg) ||
                    ((cnt_q == bcnt_reg) && (val_q < bval_reg))))
                begin
                    any_next  = 1'b1;
                    bcnt_next = cnt_q;
                    bval_next = val_q;
                end
                if (k_end)
                begin
                    state_next = tpf_pkg::ST_FIN;
                end
                else
                begin
                    k_next     = k_reg + {{(SW-1){1'b0}}, 1'b1};
                    state_next = tpf_pkg::ST_CRD;
                end
            end
            tpf_pkg::ST_FIN:
            begin
                res_next.done_res       = 1'b1;
                res_next.partition_hash = hash_reg;
                res_next.hash_matches   = (hash_reg == exp_reg);
                res_next.distinct_count = dist_reg;
                if (any_reg && (bcnt_reg >= (slot_reg >> tpf_pkg::COMMON_SH)))
                begin
                    res_next.common_found  = 1'b1;
                    res_next.common_offset = diff[31:0];
                    res_next.common_count  = bcnt_reg;
                end
                fill_next  = '0;
                slot_next  = '0;
                dist_next  = '0;
                hash_next  = tpf_pkg::FNV_BASIS;
                state_next = tpf_pkg::ST_OUT;
            end
            tpf_pkg::ST_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = tpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpf_pkg::ST_IDLE;
            base_reg  <= '0;
            exp_reg   <= tpf_pkg::HASH_RESET;
            fill_reg  <= '0;
            slot_reg  <= '0;
            dist_reg  <= '0;
            hash_reg  <= tpf_pkg::FNV_BASIS;
            step_reg  <= '0;
            k_reg     <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            exp_reg   <= exp_next;
            fill_reg  <= fill_next;
            slot_reg  <= slot_next;
            dist_reg  <= dist_next;
            hash_reg  <= hash_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        last_reg  <= last_next;
        first_reg <= first_next;
        bval_reg  <= bval_next;
        bcnt_reg  <= bcnt_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire
